// ===== rtl/bpp_pkg.sv =====
// Shared types and constants for the Bezier ping-pong trajectory generator.
// Holds the register index codes, the configuration bank struct and the
// sequencer step decode. No dependencies.
package bpp_pkg;

    // Configuration word widths
    localparam int CFG_W  = 48;
    localparam int STEP_W = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_VIA   = 2'd1,
        CFG_END   = 2'd2,
        CFG_STEP  = 2'd3
    } t_cfg_idx;

    // Configuration bank as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0]  start_pt;
        logic [CFG_W-1:0]  via_pt;
        logic [CFG_W-1:0]  end_pt;
        logic [STEP_W-1:0] step;
    } t_cfg_bank;

    // Sequencer step codes: three weight products, then three terms per axis
    typedef logic [3:0] t_step;
    localparam t_step STEP_UU   = 4'd0;
    localparam t_step STEP_UT   = 4'd1;
    localparam t_step STEP_TT   = 4'd2;
    localparam t_step STEP_X0   = 4'd3;
    localparam t_step STEP_Y0   = 4'd6;
    localparam t_step STEP_Z0   = 4'd9;
    localparam t_step STEP_LAST = 4'd11;
    localparam t_step STEP_NUM  = 4'd12;

    // Term codes within one axis: A weight, via weight, C weight
    typedef logic [1:0] t_term;
    localparam t_term TERM_A = 2'd0;
    localparam t_term TERM_B = 2'd1;
    localparam t_term TERM_C = 2'd2;

    // Axis served by a term step
    function automatic logic [1:0] step_axis(input t_step s);
        logic [1:0] r;
        r = 2'd0;
        case (s) inside
            [STEP_X0:STEP_Y0-4'd1]:   r = 2'd0;
            [STEP_Y0:STEP_Z0-4'd1]:   r = 2'd1;
            [STEP_Z0:STEP_LAST]:      r = 2'd2;
            default:                  r = 2'd0;
        endcase
        return r;
    endfunction

    // Bezier term served by a term step
    function automatic t_term step_term(input t_step s);
        t_term r;
        r = TERM_A;
        case (s) inside
            STEP_X0, STEP_Y0, STEP_Z0:                            r = TERM_A;
            STEP_X0 + 4'd1, STEP_Y0 + 4'd1, STEP_Z0 + 4'd1:       r = TERM_B;
            STEP_X0 + 4'd2, STEP_Y0 + 4'd2, STEP_Z0 + 4'd2:       r = TERM_C;
            default:                                              r = TERM_A;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bpp_ifs.sv =====
// Valid/ready channel interfaces for the Bezier ping-pong trajectory generator:
// configuration writes, loop ticks and position results.
// Depends on bpp_pkg.
interface bpp_cfg_if ();
    logic                       valid;
    logic                       ready;
    bpp_pkg::t_cfg_idx          index;
    logic [bpp_pkg::CFG_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bpp_in_if ();
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

interface bpp_out_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  pos_x;
    logic signed [COORD_WIDTH-1:0]  pos_y;
    logic signed [COORD_WIDTH-1:0]  pos_z;
    logic                           heading;
    logic                           sweep_end;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output heading, output sweep_end, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input heading, input sweep_end, output ready);
endinterface

// ===== rtl/bezier_ping_pong_trajectory.sv =====
// Channel  | Dir | Payload                                   | Accepted when
// i_cfg    | in  | index (2b), data (48b)                    | valid & ready
// i_in     | in  | advance (1b)                              | valid & ready
// o_out    | out | pos_x/y/z (COORD_WIDTH), heading, sweep_end | valid & ready
//
// One item runs 12 products through the shared multiplier (three curve weights,
// then three terms per axis), each captured in the product register and then
// folded; folding the last product moves to ST_DONE, which loads the result.
// i_in.ready is high only while idle, so a new item is taken only after the last
// one has loaded its result; a pending result does not block accepts, only the
// final load waits for o_out to drain.
// Reset is synchronous, active low; it clears the curve parameter and sweeps
// end to start. Depends on bpp_pkg, bpp_ifs, bpp_cfg_regs, bpp_mac.
module bezier_ping_pong_trajectory #(
    parameter int COORD_WIDTH     = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bpp_cfg_if.sink i_cfg,
    bpp_in_if.sink  i_in,
    bpp_out_if.source o_out
);

    localparam int CW    = COORD_WIDTH;
    localparam int PF    = PARAM_FRAC_BITS;
    localparam int TW    = PF + 1;
    localparam int MA    = PF + 3;
    localparam int MB    = (PF + 2 > CW) ? PF + 2 : CW;
    localparam int PW    = MA + MB;
    localparam int AW    = PW + 2;
    localparam int RW    = AW - PF;
    localparam int SW    = ((TW > bpp_pkg::STEP_W) ? TW : bpp_pkg::STEP_W) + 1;
    localparam int EXT_W = (3 * CW > bpp_pkg::CFG_W) ? 3 * CW : bpp_pkg::CFG_W;

    localparam logic [TW-1:0]        T_ONE  = TW'(1) << PF;
    localparam logic [SW-1:0]        T_MAX  = SW'({TW{1'b1}});
    localparam logic signed [MA-1:0] U_ONE  = MA'(1) << PF;
    localparam logic signed [AW-1:0] HALF_A = AW'(1) << (PF - 1);
    localparam logic signed [PW:0]   HALF_W = (PW + 1)'(1) << (PF - 1);
    localparam logic signed [RW-1:0] SAT_HI = {{(RW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                 r_state;
    bpp_pkg::t_step         r_step;
    bpp_pkg::t_step         r_cstep;
    logic                   r_cvalid;
    logic [TW-1:0]          r_t;
    logic                   r_dir;
    logic signed [MA-1:0]   r_w [3];
    logic signed [AW-1:0]   r_acc;
    logic signed [CW-1:0]   r_pos [3];
    logic                   r_ovalid;
    logic signed [CW-1:0]   r_opos [3];
    logic                   r_oheading;
    logic                   r_osweep;

    bpp_pkg::t_cfg_bank     cfg_bank;
    logic                   in_acc;
    logic                   out_load;
    logic                   flip;
    logic                   issue;
    logic [SW-1:0]          t_sum;
    logic [TW-1:0]          n_t;
    logic signed [MA-1:0]   t_a;
    logic signed [MA-1:0]   u_a;
    logic signed [MA-1:0]   op_a;
    logic signed [MB-1:0]   op_b;
    logic signed [PW-1:0]   prod;
    logic [EXT_W-1:0]       pt_ext;
    logic [1:0]             i_axis;
    bpp_pkg::t_term         i_term;
    logic [1:0]             c_axis;
    bpp_pkg::t_term         c_term;
    logic signed [AW-1:0]   p_ext;
    logic signed [AW-1:0]   n_acc;
    logic signed [AW-1:0]   r_sum;
    logic signed [RW-1:0]   rnd;
    logic signed [CW-1:0]   sat_val;
    logic signed [PW:0]     w_sum;
    logic signed [MA-1:0]   n_w;

    bpp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_bank  (cfg_bank)
    );

    bpp_mac #(
        .A_W (MA),
        .B_W (MB)
    ) u_mac (
        .i_clk  (i_clk),
        .i_en   (issue),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    // Handshakes and sweep control
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && (r_state == ST_IDLE);
    assign out_load   = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);
    assign flip       = (r_t > T_ONE);
    assign issue      = (r_state == ST_RUN) && (r_step < bpp_pkg::STEP_NUM);

    // Advance the parameter with saturation
    always_comb begin
        t_sum = SW'(r_t) + SW'(cfg_bank.step);
        n_t   = (t_sum > T_MAX) ? r_t | {TW{1'b1}} : t_sum[TW-1:0];
    end

    // Select multiplier operands for the issued step
    always_comb begin
        t_a    = MA'(r_t);
        u_a    = U_ONE - t_a;
        i_axis = bpp_pkg::step_axis(r_step);
        i_term = bpp_pkg::step_term(r_step);
        case (i_term)
            bpp_pkg::TERM_A: pt_ext = EXT_W'(r_dir ? cfg_bank.start_pt : cfg_bank.end_pt);
            bpp_pkg::TERM_B: pt_ext = EXT_W'(cfg_bank.via_pt);
            bpp_pkg::TERM_C: pt_ext = EXT_W'(r_dir ? cfg_bank.end_pt : cfg_bank.start_pt);
            default:         pt_ext = '0;
        endcase
        if (r_step < bpp_pkg::STEP_X0) begin
            op_a = (r_step == bpp_pkg::STEP_TT) ? t_a : u_a;
            op_b = (r_step == bpp_pkg::STEP_UU) ? MB'(u_a) : MB'(t_a);
        end else begin
            op_a = r_w[i_term];
            op_b = MB'($signed(pt_ext[i_axis * CW +: CW]));
        end
    end

    // Fold the registered product: round a weight or accumulate a term
    always_comb begin
        c_axis  = bpp_pkg::step_axis(r_cstep);
        c_term  = bpp_pkg::step_term(r_cstep);
        p_ext   = AW'(prod);
        n_acc   = (c_term == bpp_pkg::TERM_A) ? p_ext : r_acc + p_ext;
        r_sum   = n_acc + HALF_A;
        rnd     = r_sum[AW-1:PF];
        if (rnd > SAT_HI) begin
            sat_val = SAT_HI[CW-1:0];
        end else if (rnd < SAT_LO) begin
            sat_val = SAT_LO[CW-1:0];
        end else begin
            sat_val = rnd[CW-1:0];
        end
        w_sum = ((r_cstep == bpp_pkg::STEP_UT) ? {prod, 1'b0} : (PW + 1)'(prod)) + HALF_W;
        n_w   = w_sum[PF +: MA];
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_cstep  <= '0;
            r_cvalid <= 1'b0;
            r_t      <= '0;
            r_dir    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads now
            if (o_out.ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in.advance) begin
                            r_t <= n_t;
                        end
                        r_step   <= '0;
                        r_cvalid <= 1'b0;
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        r_step <= r_step + bpp_pkg::t_step'(1);
                    end
                    r_cstep  <= r_step;
                    r_cvalid <= issue;
                    if (r_cvalid) begin
                        if (r_cstep < bpp_pkg::STEP_X0) begin
                            r_w[r_cstep[1:0]] <= n_w;
                        end else begin
                            r_acc <= n_acc;
                            if (c_term == bpp_pkg::TERM_C) begin
                                r_pos[c_axis] <= sat_val;
                            end
                        end
                        if (r_cstep == bpp_pkg::STEP_LAST) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    r_cvalid <= 1'b0;
                    if (out_load) begin
                        r_ovalid   <= 1'b1;
                        r_opos     <= r_pos;
                        r_oheading <= r_dir;
                        r_osweep   <= flip;
                        if (flip) begin
                            r_t   <= '0;
                            r_dir <= ~r_dir;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.pos_x     = r_opos[0];
    assign o_out.pos_y     = r_opos[1];
    assign o_out.pos_z     = r_opos[2];
    assign o_out.heading   = r_oheading;
    assign o_out.sweep_end = r_osweep;

`ifndef ASSERT_OFF
    // A reversal restarts the parameter at zero
    ap_flip_clears_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && flip) |=> (r_t == '0))
        else $error("parameter not cleared on sweep reversal");

    // Direction toggles exactly when a reversal is reported
    ap_dir_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_dir == ($past(r_dir) ^ $past(flip))))
        else $error("direction changed without a reversal");

    // An accepted item starts a fresh sequence
    ap_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RUN && r_step == '0 && !r_cvalid))
        else $error("sequence did not restart on accept");

    // The folded product always belongs to the step issued just before
    ap_fold_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cvalid) |-> (r_cstep + bpp_pkg::t_step'(1) == r_step))
        else $error("product folded out of order");
`endif

endmodule

// ===== rtl/bpp_cfg_regs.sv =====
// Configuration register bank: control points and parameter step.
// Takes writes from the configuration channel. Depends on bpp_pkg, bpp_ifs.
module bpp_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bpp_cfg_if.sink             i_cfg,
    output bpp_pkg::t_cfg_bank  o_bank
);

    localparam logic [bpp_pkg::STEP_W-1:0] STEP_RESET = 16'd131;

    bpp_pkg::t_cfg_bank r_bank;

    // Always able to take a write
    assign i_cfg.ready = 1'b1;
    assign o_bank      = r_bank;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank.start_pt <= '0;
            r_bank.via_pt   <= '0;
            r_bank.end_pt   <= '0;
            r_bank.step     <= STEP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bpp_pkg::CFG_START: r_bank.start_pt <= i_cfg.data;
                bpp_pkg::CFG_VIA:   r_bank.via_pt   <= i_cfg.data;
                bpp_pkg::CFG_END:   r_bank.end_pt   <= i_cfg.data;
                bpp_pkg::CFG_STEP:  r_bank.step     <= i_cfg.data[bpp_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/bpp_mac.sv =====
// Shared signed multiplier with a registered product.
// Used for every weight and every coordinate term. No dependencies.
module bpp_mac #(
    parameter int A_W = 19,
    parameter int B_W = 18
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [B_W-1:0]   i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    // Capture one product per issued step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== test/bezier_ping_pong_trajectory_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bezier_ping_pong_trajectory: drives loop ticks and
// register writes over valid/ready channels and checks every position item.
// Depends on bpp_pkg, bpp_ifs and the block itself.
module bezier_ping_pong_trajectory_tb;

    localparam int     COORD_W      = 16;
    localparam int     FRAC_BITS    = 16;
    localparam longint PARAM_ONE    = 64'sd1 << FRAC_BITS;
    localparam longint PARAM_MAX    = (64'sd1 << (FRAC_BITS + 1)) - 1;
    localparam longint COORD_MAX    = (64'sd1 << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     CYCLE_LIMIT  = 400000;

    // One position item as seen on the output channel
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      heading;
        logic                      sweep_end;
    } pos_item_t;

    logic i_clk;
    logic i_rst_n;

    bpp_cfg_if                        cfg_if ();
    bpp_in_if                         tick_if ();
    bpp_out_if #(.COORD_WIDTH(COORD_W)) pos_if ();

    bezier_ping_pong_trajectory #(
        .COORD_WIDTH    (COORD_W),
        .PARAM_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (tick_if),
        .o_out  (pos_if)
    );

    // Trajectory state and register copies
    logic [bpp_pkg::CFG_W-1:0]  pt_start  = '0;
    logic [bpp_pkg::CFG_W-1:0]  pt_via    = '0;
    logic [bpp_pkg::CFG_W-1:0]  pt_end    = '0;
    logic [bpp_pkg::STEP_W-1:0] step_inc  = 16'd131;
    logic [FRAC_BITS:0]         t_param   = '0;
    logic                       sweep_dir = 1'b0;

    pos_item_t expected_pos[$];
    int        error_count    = 0;
    int        cycle_count    = 0;
    int        src_idle_pct   = 0;
    int        snk_idle_pct   = 0;
    int        stall_request  = 0;
    int        stall_left     = 0;

    // Clock: 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Round half up back to the coordinate scale (arithmetic shift floors)
    function automatic longint round_frac(input longint v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint coord_of(input logic [bpp_pkg::CFG_W-1:0] p, input int k);
        return longint'($signed(p[k*COORD_W +: COORD_W]));
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX[COORD_W-1:0];
        if (v < COORD_MIN) return COORD_MIN[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // Advance the curve parameter, evaluate the point, then wrap and flip
    function automatic pos_item_t eval_trajectory(input logic adv);
        pos_item_t                 r;
        logic [FRAC_BITS+1:0]      sum;
        longint                    t, u, w0, w1, w2;
        logic [bpp_pkg::CFG_W-1:0] pa, pc;
        longint                    acc[3];
        if (adv) begin
            sum = {1'b0, t_param} + step_inc;
            t_param = (sum > PARAM_MAX) ? PARAM_MAX[FRAC_BITS:0] : sum[FRAC_BITS:0];
        end
        t  = longint'(t_param);
        u  = PARAM_ONE - t;
        w0 = round_frac(u * u);
        w1 = round_frac(2 * u * t);
        w2 = round_frac(t * t);
        pa = sweep_dir ? pt_start : pt_end;
        pc = sweep_dir ? pt_end : pt_start;
        for (int k = 0; k < 3; k++)
            acc[k] = round_frac(w0 * coord_of(pa, k) + w1 * coord_of(pt_via, k)
                                + w2 * coord_of(pc, k));
        r.x         = clamp_coord(acc[0]);
        r.y         = clamp_coord(acc[1]);
        r.z         = clamp_coord(acc[2]);
        r.heading   = sweep_dir;
        r.sweep_end = 1'b0;
        if (t > PARAM_ONE) begin
            t_param     = '0;
            sweep_dir   = ~sweep_dir;
            r.sweep_end = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            error_count++;
        end
    endtask

    // Check each position item against the oldest expectation, then track
    // register writes and accepted ticks
    always @(posedge i_clk) begin
        pos_item_t want;
        if (!i_rst_n) begin
            pt_start  = '0;
            pt_via    = '0;
            pt_end    = '0;
            step_inc  = 16'd131;
            t_param   = '0;
            sweep_dir = 1'b0;
        end else begin
            if (pos_if.valid && pos_if.ready) begin
                if (expected_pos.size() == 0) begin
                    $display({"%0t: unexpected position item, expected none, ",
                              "actual x=%0d y=%0d z=%0d"},
                             $time, pos_if.pos_x, pos_if.pos_y, pos_if.pos_z);
                    error_count++;
                end else begin
                    want = expected_pos.pop_front();
                    check_field("pos_x", want.x, pos_if.pos_x);
                    check_field("pos_y", want.y, pos_if.pos_y);
                    check_field("pos_z", want.z, pos_if.pos_z);
                    check_field("heading", {15'd0, want.heading}, {15'd0, pos_if.heading});
                    check_field("sweep_end", {15'd0, want.sweep_end},
                                {15'd0, pos_if.sweep_end});
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    bpp_pkg::CFG_START: pt_start = cfg_if.data;
                    bpp_pkg::CFG_VIA:   pt_via   = cfg_if.data;
                    bpp_pkg::CFG_END:   pt_end   = cfg_if.data;
                    bpp_pkg::CFG_STEP:  step_inc = cfg_if.data[bpp_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (tick_if.valid && tick_if.ready)
                expected_pos.push_back(eval_trajectory(tick_if.advance));
        end
    end

    // Receiver: random idling, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            pos_if.ready <= 1'b0;
            stall_left--;
        end else begin
            pos_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Hard stop
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bezier_ping_pong_trajectory_tb: FAIL");
            $finish;
        end
    end

    // Offer one tick, idling at random first; valid stays high on return
    task automatic send_tick(input logic adv);
        while ($urandom_range(99) < src_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.advance <= adv;
        do @(posedge i_clk); while (!tick_if.ready);
    endtask

    // Drop valid and wait until every expected item has come back
    task automatic wait_drained();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pos.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bpp_pkg::t_cfg_idx idx,
                             input logic [bpp_pkg::CFG_W-1:0] val);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Control point with each coordinate biased toward the extremes
    function automatic logic [bpp_pkg::CFG_W-1:0] pick_point();
        logic [bpp_pkg::CFG_W-1:0] p;
        logic [31:0]               rv;
        for (int k = 0; k < 3; k++) begin
            rv = $urandom;
            case ($urandom_range(5))
                0:       p[k*COORD_W +: COORD_W] = 16'h7FFF;
                1:       p[k*COORD_W +: COORD_W] = 16'h8000;
                2:       p[k*COORD_W +: COORD_W] = 16'h0000;
                default: p[k*COORD_W +: COORD_W] = rv[COORD_W-1:0];
            endcase
        end
        return p;
    endfunction

    // Step word with random upper bits; mostly steps that finish a sweep quickly
    function automatic logic [bpp_pkg::CFG_W-1:0] pick_step();
        logic [bpp_pkg::CFG_W-1:0] d;
        logic [63:0]               w;
        logic [31:0]               rv;
        w = {$urandom, $urandom};
        d = w[bpp_pkg::CFG_W-1:0];
        case ($urandom_range(3))
            0, 1:    rv = $urandom_range(65535, 2048);
            2:       rv = $urandom_range(65535, 0);
            default: rv = $urandom_range(2047, 1);
        endcase
        d[bpp_pkg::STEP_W-1:0] = rv[bpp_pkg::STEP_W-1:0];
        return d;
    endfunction

    // Zero control points with the reset step give the origin
    task automatic test_reset_state();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Full-scale points: overshoot past one saturates both ways
    task automatic test_extreme_points();
        write_reg(bpp_pkg::CFG_START, {3{16'h7FFF}});
        write_reg(bpp_pkg::CFG_VIA, {3{16'h8000}});
        write_reg(bpp_pkg::CFG_END, {16'h8000, 16'h0000, 16'h7FFF});
        write_reg(bpp_pkg::CFG_STEP, 48'hFFFF_FFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        write_reg(bpp_pkg::CFG_START, {3{16'h8000}});
        write_reg(bpp_pkg::CFG_VIA, {3{16'h7FFF}});
        write_reg(bpp_pkg::CFG_END, {3{16'h8000}});
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // Parameter lands on exactly one without wrapping, then overshoots
    task automatic test_exact_one();
        write_reg(bpp_pkg::CFG_STEP, 48'h0000_0000_8000);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // Zero step holds the parameter whatever the advance flag says
    task automatic test_zero_step();
        write_reg(bpp_pkg::CFG_VIA, {16'h1234, 16'hEDCB, 16'h4000});
        write_reg(bpp_pkg::CFG_STEP, {32'hA5A5_5A5A, 16'h0000});
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Hold the receiver off while ticks keep coming, so the input stalls
    task automatic test_output_stall();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(bpp_pkg::CFG_STEP, 48'd4099);
        stall_request = 300;
        repeat (12) send_tick(1'(($urandom_range(1))));
        wait_drained();
    endtask

    // Random sweeps in three idling phases, reprogrammed between bursts
    task automatic test_random_sweeps();
        int n;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 23;
                    snk_idle_pct = 63;
                end
                1: begin
                    src_idle_pct = 63;
                    snk_idle_pct = 23;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int cfg_round = 0; cfg_round < 5; cfg_round++) begin
                if (cfg_round == 0 || $urandom_range(1))
                    write_reg(bpp_pkg::CFG_START, pick_point());
                if (cfg_round == 0 || $urandom_range(1))
                    write_reg(bpp_pkg::CFG_VIA, pick_point());
                if (cfg_round == 0 || $urandom_range(1))
                    write_reg(bpp_pkg::CFG_END, pick_point());
                if (cfg_round == 0 || $urandom_range(1))
                    write_reg(bpp_pkg::CFG_STEP, pick_step());
                n = $urandom_range(64, 30);
                repeat (n) send_tick(1'($urandom_range(99) < 80));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= bpp_pkg::CFG_START;
        cfg_if.data     <= '0;
        tick_if.valid   <= 1'b0;
        tick_if.advance <= 1'b0;
        src_idle_pct = 23;
        snk_idle_pct = 63;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extreme_points();
        test_exact_one();
        test_zero_step();
        test_output_stall();
        test_random_sweeps();
        wait_drained();

        if (expected_pos.size() != 0) begin
            $display("%0t: %0d position items never arrived", $time, expected_pos.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("bezier_ping_pong_trajectory_tb: PASS");
        end else begin
            $display("bezier_ping_pong_trajectory_tb: FAIL");
        end
        $finish;
    end

endmodule
